// ----- sv/iff_pkg.sv -----
package iff_pkg;

  // Largest field width honored; wider requests are clamped.
  localparam int MAX_WIDTH = 63;

  localparam int VAL_W   = 32;           // argument bits
  localparam int DIG_W   = 4;            // widest digit (hex / BCD nibble)
  localparam int BCD_N   = 10;           // decimal digits of a 32-bit magnitude
  localparam int NUM_W   = BCD_N * DIG_W; // left-aligned digit register
  localparam int FW_W    = 6;            // field_width / precision width
  localparam int CHAR_W  = 8;
  localparam int ITER_W  = $clog2(VAL_W);

  // Digit counts of each radix, left-aligned in the digit register
  localparam logic [FW_W-1:0] NDIG_BIN = FW_W'(VAL_W);
  localparam logic [FW_W-1:0] NDIG_OCT = FW_W'((VAL_W + 2) / 3);
  localparam logic [FW_W-1:0] NDIG_HEX = FW_W'(VAL_W / 4);
  localparam logic [FW_W-1:0] NDIG_DEC = FW_W'(BCD_N);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 8'd55; // 'A' - 10

  typedef enum logic [2:0] {
    ACT_CHAR = 3'd0,
    ACT_SDEC = 3'd1,
    ACT_BIN  = 3'd2,
    ACT_OCT  = 3'd3,
    ACT_UDEC = 3'd4,
    ACT_HEX  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    RDX_BIN,
    RDX_OCT,
    RDX_HEX,
    RDX_DEC
  } radix_e;

  typedef enum logic {
    OP_DABBLE,
    OP_DIGIT
  } shift_op_e;

  typedef struct packed {
    shift_op_e op;
    radix_e    radix;
  } shift_ctl_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [VAL_W-1:0] value;
    logic [FW_W-1:0]  field_width;
    logic [FW_W-1:0]  precision;
    logic             left_justify;
    logic             zero_pad;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    return (d < 4'd10) ? (CH_ZERO + dw) : (CH_ALPHA + dw);
  endfunction

endpackage

// ----- sv/iff_shift_unit.sv -----
module iff_shift_unit (
  input  iff_pkg::shift_ctl_t              ctl_i,
  input  logic [iff_pkg::NUM_W-1:0]        num_i,
  input  logic [iff_pkg::VAL_W-1:0]        bin_i,
  output logic [iff_pkg::NUM_W-1:0]        num_o,
  output logic [iff_pkg::VAL_W-1:0]        bin_o,
  output logic [iff_pkg::DIG_W-1:0]        top_o
);
  import iff_pkg::*;

  logic [NUM_W-1:0] adj;

  // Add-3 correction on every BCD nibble of at least five
  always_comb begin
    for (int i = 0; i < BCD_N; i++) begin
      adj[i*DIG_W +: DIG_W] = (num_i[i*DIG_W +: DIG_W] >= 4'd5) ?
                              num_i[i*DIG_W +: DIG_W] + 4'd3 :
                              num_i[i*DIG_W +: DIG_W];
    end
  end

  always_comb begin
    unique case (ctl_i.radix)
      RDX_BIN: top_o = {3'b000, num_i[NUM_W-1]};
      RDX_OCT: top_o = {1'b0, num_i[NUM_W-1 -: 3]};
      default: top_o = num_i[NUM_W-1 -: DIG_W];
    endcase
  end

  always_comb begin
    bin_o = bin_i;
    num_o = num_i;
    unique case (ctl_i.op)
      OP_DABBLE: begin
        num_o = {adj[NUM_W-2:0], bin_i[VAL_W-1]};
        bin_o = {bin_i[VAL_W-2:0], 1'b0};
      end
      OP_DIGIT: begin
        unique case (ctl_i.radix)
          RDX_BIN: num_o = {num_i[NUM_W-2:0], 1'b0};
          RDX_OCT: num_o = {num_i[NUM_W-4:0], 3'b000};
          default: num_o = {num_i[NUM_W-DIG_W-1:0], {DIG_W{1'b0}}};
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/integer_field_formatter.sv -----
// Formats one printf-style integer field per input beat and streams its
// ASCII characters one beat each, most significant first, with last set on
// the final character. A field passes through an accept, a double-dabble
// conversion for decimal kinds, a normalize pass that drops leading zero
// digits (up to 31 for binary; skipped for a character), a setup step, then
// one character per cycle while the sink keeps ready high; the shared
// shift/adjust unit drives the conversion, normalize and emit steps. The
// input stays not ready until the last character is loaded into the output
// register. Unknown conversion kinds, and a zero character with no width,
// produce no beats at all.
module integer_field_formatter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  iff_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output iff_pkg::out_t   out_data_o
);
  import iff_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SETUP,
    ST_EMIT
  } state_e;

  state_e             state_q;
  radix_e             radix_q;
  logic               is_char_q;
  logic [CHAR_W-1:0]  chr_q;
  logic               neg_q;
  logic               sign_q;
  logic [NUM_W-1:0]   num_q;
  logic [VAL_W-1:0]   bin_q;
  logic [ITER_W-1:0]  iter_q;
  logic [FW_W-1:0]    ndig_q;
  logic [FW_W-1:0]    width_q;
  logic [FW_W-1:0]    prec_q;
  logic               left_q;
  logic               zpad_q;
  logic [FW_W-1:0]    pad_q;
  logic [FW_W-1:0]    txt_q;
  logic               ov_q;
  out_t               od_q;

  shift_ctl_t         ctl;
  logic [NUM_W-1:0]   num_nx;
  logic [VAL_W-1:0]   bin_nx;
  logic [DIG_W-1:0]   top;

  logic [FW_W-1:0]    len;
  logic [FW_W-1:0]    wclamp;
  logic [FW_W-1:0]    fill;
  logic [FW_W:0]      remain;
  logic               load;
  logic               pad_now;
  logic [CHAR_W-1:0]  pad_char;
  logic [CHAR_W-1:0]  txt_char;
  logic [VAL_W-1:0]   mag;

  assign ctl.op    = (state_q == ST_CONV) ? OP_DABBLE : OP_DIGIT;
  assign ctl.radix = radix_q;

  iff_shift_unit u_shift (
    .ctl_i (ctl),
    .num_i (num_q),
    .bin_i (bin_q),
    .num_o (num_nx),
    .bin_o (bin_nx),
    .top_o (top)
  );

  always_comb begin
    len = is_char_q ? FW_W'(chr_q != '0) : ndig_q + FW_W'(neg_q);
    if (prec_q != '0 && prec_q < len) begin
      len = prec_q;
    end
    wclamp = (32'(width_q) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : width_q;
    fill   = (wclamp > len) ? wclamp - len : '0;
  end

  assign mag      = in_data_i.value[VAL_W-1] ? VAL_W'(0) - in_data_i.value
                                             : in_data_i.value;
  assign remain   = {1'b0, pad_q} + {1'b0, txt_q};
  assign load     = !ov_q || out_ready_i;
  assign pad_now  = (!left_q && pad_q != '0) || txt_q == '0;
  assign pad_char = zpad_q ? CH_ZERO : CH_SPACE;
  assign txt_char = is_char_q ? chr_q : (sign_q ? CH_MINUS : digit_char(top));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      iter_q  <= '0;
    end else begin
      // drop a taken beat; the emit state refills the register itself
      if (out_ready_i && state_q != ST_EMIT) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            width_q   <= in_data_i.field_width;
            prec_q    <= in_data_i.precision;
            left_q    <= in_data_i.left_justify;
            zpad_q    <= in_data_i.zero_pad;
            is_char_q <= (in_data_i.action == ACT_CHAR);
            neg_q     <= (in_data_i.action == ACT_SDEC) && in_data_i.value[VAL_W-1];
            chr_q     <= in_data_i.value[CHAR_W-1:0];
            iter_q    <= '0;
            unique case (in_data_i.action) inside
              ACT_CHAR: begin
                state_q   <= ST_SETUP;
              end
              ACT_SDEC, ACT_UDEC: begin
                bin_q   <= (in_data_i.action == ACT_SDEC) ? mag : in_data_i.value;
                num_q   <= '0;
                radix_q <= RDX_DEC;
                state_q <= ST_CONV;
              end
              ACT_BIN: begin
                num_q   <= {in_data_i.value, {(NUM_W-VAL_W){1'b0}}};
                ndig_q  <= NDIG_BIN;
                radix_q <= RDX_BIN;
                state_q <= ST_NORM;
              end
              ACT_OCT: begin
                num_q   <= {1'b0, in_data_i.value, {(NUM_W-VAL_W-1){1'b0}}};
                ndig_q  <= NDIG_OCT;
                radix_q <= RDX_OCT;
                state_q <= ST_NORM;
              end
              ACT_HEX: begin
                num_q   <= {in_data_i.value, {(NUM_W-VAL_W){1'b0}}};
                ndig_q  <= NDIG_HEX;
                radix_q <= RDX_HEX;
                state_q <= ST_NORM;
              end
              default: ; // drop unknown kinds
            endcase
          end
        end
        ST_CONV: begin
          num_q  <= num_nx;
          bin_q  <= bin_nx;
          iter_q <= iter_q + 1'b1;
          if (iter_q == ITER_W'(VAL_W - 1)) begin
            ndig_q  <= NDIG_DEC;
            state_q <= ST_NORM;
          end
        end
        ST_NORM: begin
          // drop leading zero digits, keep at least one
          if (ndig_q > FW_W'(1) && top == '0) begin
            num_q  <= num_nx;
            ndig_q <= ndig_q - 1'b1;
          end else begin
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          pad_q   <= fill;
          txt_q   <= len;
          sign_q  <= neg_q;
          state_q <= (fill == '0 && len == '0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (load) begin
            ov_q         <= 1'b1;
            od_q.last    <= (remain == (FW_W+1)'(1));
            if (pad_now) begin
              od_q.character <= pad_char;
              pad_q          <= pad_q - 1'b1;
            end else begin
              od_q.character <= txt_char;
              txt_q          <= txt_q - 1'b1;
              if (!is_char_q) begin
                if (sign_q) begin
                  sign_q <= 1'b0;
                end else begin
                  num_q <= num_nx;
                end
              end
            end
            if (remain == (FW_W+1)'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

// ----- sv/iff_checker.sv -----
module iff_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input iff_pkg::in_t    in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input iff_pkg::out_t   out_data_o
);
  import iff_pkg::*;

  logic in_beat;
  logic known_kind;

  assign in_beat    = in_valid_i && in_ready_o;
  assign known_kind = (in_data_i.action <= ACT_HEX);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // A known field occupies the block after its accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && known_kind |=> !in_ready_o)
    else $error("input ready right after a field was accepted");

  // An unknown kind is dropped without stalling the input
  a_drop_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !known_kind |=> in_ready_o)
    else $error("unknown kind was not dropped");

  // Mid-field beats never overlap an open input
  a_no_accept_mid_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input ready while a field is still streaming");

endmodule

bind integer_field_formatter iff_checker u_iff_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
